>>> sv/pkvba_pkg.sv
package pkvba_pkg;

  localparam int unsigned LEN_W = 10;
  localparam logic [LEN_W-1:0] LEN_MAX = 10'd1023;
  localparam int unsigned QUERY_MAX = 32;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_FREE   = 3'd1;
  localparam logic [2:0] OP_SHARE  = 3'd2;
  localparam logic [2:0] OP_TRIM   = 3'd3;
  localparam logic [2:0] OP_EVICT  = 3'd4;
  localparam logic [2:0] OP_QUERY  = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_NO_FREE = 2'd2;
  localparam logic [1:0] ST_ABSENT  = 2'd3;

  typedef struct packed {
    logic [2:0]       op;
    logic [3:0]       request;
    logic [3:0]       source_request;
    logic [LEN_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       block_index;
    logic             block_valid;
    logic [LEN_W-1:0] seq_length;
    logic [8:0]       blocks_in_use;
    logic             last;
  } out_item_t;

endpackage

>>> sv/pkvba_ref_store.sv
module pkvba_ref_store #(
  parameter int unsigned POOL_BLOCKS = 256,
  parameter int unsigned BW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [BW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o,
  input  logic          wr_en_i,
  input  logic [BW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i
);

  logic [7:0]             mem [POOL_BLOCKS];
  logic [POOL_BLOCKS-1:0] vld_q;
  logic [7:0]             rd_q;
  logic                   rv_q;

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rv_q  <= 1'b0;
    end else begin
      rv_q <= vld_q[rd_addr_i];
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr_i];
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rv_q ? rd_q : 8'd0;

endmodule

>>> sv/pkvba_map_ram.sv
module pkvba_map_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW = 9,
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

endmodule

>>> sv/paged_kv_block_allocator.sv
// paged cache block allocator: reference counted block pool, per-request block lists
// input channel: one command beat (op, request, source_request, amount), taken only
//   while no command is in progress; in_stall_o is high from acceptance until the
//   command's last result beat is loaded into the output register
// output: one beat per command, one per listed block (up to QUERY_MAX) for a query;
//   the output register holds a beat while out_stall_i is high and the command
//   engine waits there before loading the next beat
// steps: dispatch, then
//   append: check, map read and advance per touched block already listed; check,
//   free-block scan and advance per new block; then a closing check
//   free, trim, evict: check, map read, update per released block, closing check
//   share prefix: source check, then check, map read, count update per shared block,
//   then a closing check; query: map read and data capture per listed block
//   each result beat then loads into the output register
// throughput: one command at a time, the next is taken the cycle after the last
//   result beat is loaded
// blocks_in_use is a running counter updated whenever a reference count leaves or reaches zero
// reset: all slots absent, all reference counts zero (per-block valid bits), no
//   clearing pass; the block is idle and takes a command straight out of reset
module paged_kv_block_allocator #(
  parameter int unsigned POOL_BLOCKS = 256,
  parameter int unsigned BLOCK_TOKENS = 16,
  parameter int unsigned MAX_REQUESTS = 16,
  parameter int unsigned MAX_BLOCKS_PER_REQ = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pkvba_pkg::in_item_t  in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pkvba_pkg::out_item_t out_o
);

  localparam int unsigned LW   = pkvba_pkg::LEN_W;
  localparam int unsigned BW   = $clog2(POOL_BLOCKS);
  localparam int unsigned UW   = $clog2(POOL_BLOCKS + 1);
  localparam int unsigned RW   = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned CW   = $clog2(MAX_BLOCKS_PER_REQ + 1);
  localparam int unsigned MD   = MAX_REQUESTS * MAX_BLOCKS_PER_REQ;
  localparam int unsigned MW   = (MD > 1) ? $clog2(MD) : 1;
  localparam int unsigned ACW  = $clog2(MAX_BLOCKS_PER_REQ * BLOCK_TOKENS + 1);
  localparam int unsigned DW   = LW + $clog2(BLOCK_TOKENS + 1) + 1;
  localparam int unsigned DL   = $clog2(BLOCK_TOKENS);
  localparam int unsigned DK   = LW + DL;
  localparam int unsigned DMUL = ((1 << DK) + BLOCK_TOKENS - 1) / BLOCK_TOKENS;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_A_CHK, S_A_SCAN, S_A_MAP, S_A_ADV,
    S_T_CHK, S_T_MAP, S_T_REF, S_SH_SRC, S_SH_CHK, S_SH_MAP, S_SH_REF,
    S_Q_RD, S_Q_DAT, S_EMIT
  } state_e;

  state_e               state_q;
  pkvba_pkg::in_item_t  in_q;
  pkvba_pkg::out_item_t out_q;
  logic                 out_v_q;

  logic [LW-1:0]  slen_q [MAX_REQUESTS];
  logic [CW-1:0]  bcnt_q [MAX_REQUESTS];
  logic [MAX_REQUESTS-1:0] sval_q;

  logic [LW-1:0]  rem_q, cur_q, off_q, seqo_q, pres_q;
  logic [1:0]     st_q;
  logic [BW-1:0]  blk_q, scan_q, chk_q;
  logic           bv_q, last_q, chk_v_q;
  logic [CW-1:0]  i_q, scnt_q, qn_q;
  logic [ACW-1:0] acc_q;
  logic [UW-1:0]  used_q;

  // memory ports
  logic [BW-1:0] ref_rd_addr, ref_wr_addr;
  logic [7:0]    ref_rdata, ref_wdata;
  logic          ref_wr_en;
  logic [MW-1:0] map_rd_addr, map_wr_addr;
  logic [BW-1:0] map_rdata, map_wdata;
  logic          map_wr_en;

  logic [RW-1:0] req_idx, src_idx, slot;
  logic          req_in, src_in;
  logic [LW-1:0] cur_len;
  logic [CW-1:0] cur_cnt;
  logic          cur_val;
  logic [MW-1:0] rbase, sbase;
  logic          found;
  logic          emit_load;
  logic [LW-1:0] take_a, take_b, take, off_sum;
  logic [2*LW:0] dv_prod;
  logic [LW-1:0] dv_q, dv_rem;
  logic [DW-1:0] drop;
  logic [LW-1:0] trim_len;
  logic          t_more;

  assign req_idx = RW'(in_q.request);
  assign src_idx = RW'(in_q.source_request);
  assign req_in  = 32'(in_q.request) < MAX_REQUESTS;
  assign src_in  = 32'(in_q.source_request) < MAX_REQUESTS;
  assign slot    = (state_q == S_SH_SRC) ? src_idx : req_idx;
  assign cur_len = slen_q[slot];
  assign cur_cnt = bcnt_q[slot];
  assign cur_val = sval_q[slot];
  assign rbase   = MW'(32'(req_idx) * MAX_BLOCKS_PER_REQ);
  assign sbase   = MW'(32'(src_idx) * MAX_BLOCKS_PER_REQ);

  assign found = (state_q == S_A_SCAN) && chk_v_q && (ref_rdata == 8'd0);
  assign emit_load = (state_q == S_EMIT) && (!out_v_q || !out_stall_i);

  // append step size: rest of the current block, clipped by tokens left and length cap
  always_comb begin
    take_a = LW'(BLOCK_TOKENS) - off_q;
    if (take_a > rem_q) take_a = rem_q;
    take_b = pkvba_pkg::LEN_MAX - cur_len;
    take = (take_a > take_b) ? take_b : take_a;
    off_sum = off_q + take;
  end

  // block and offset of the current length by reciprocal multiply
  always_comb begin
    dv_prod = (2*LW+1)'(cur_len) * (2*LW+1)'(DMUL);
    dv_q    = LW'(dv_prod >> DK);
    dv_rem  = cur_len - LW'(dv_q * LW'(BLOCK_TOKENS));
  end

  always_comb begin
    if (in_q.op == pkvba_pkg::OP_TRIM) begin
      drop = DW'(in_q.amount) * DW'(BLOCK_TOKENS);
    end else begin
      drop = DW'(acc_q);
    end
    trim_len = (DW'(cur_len) > drop) ? LW'(DW'(cur_len) - drop) : '0;
    case (in_q.op)
      pkvba_pkg::OP_FREE: t_more = cur_cnt != '0;
      pkvba_pkg::OP_TRIM: t_more = (cur_cnt != '0) && (32'(i_q) < 32'(in_q.amount));
      default:            t_more = (cur_cnt != '0) && (32'(acc_q) < 32'(in_q.amount));
    endcase
  end

  always_comb begin
    ref_rd_addr = scan_q;
    ref_wr_en   = 1'b0;
    ref_wr_addr = blk_q;
    ref_wdata   = 8'd0;
    map_rd_addr = MW'(rbase + MW'(i_q));
    map_wr_en   = 1'b0;
    map_wr_addr = MW'(rbase + MW'(i_q));
    map_wdata   = blk_q;
    case (state_q)
      S_A_CHK:  map_rd_addr = MW'(rbase + MW'(cur_q));
      S_A_SCAN: begin
        if (found) begin
          ref_wr_en   = 1'b1;
          ref_wr_addr = chk_q;
          ref_wdata   = 8'd1;
          map_wr_en   = 1'b1;
          map_wr_addr = MW'(rbase + MW'(cur_cnt));
          map_wdata   = chk_q;
        end
      end
      S_T_CHK:  map_rd_addr = MW'(rbase + MW'(cur_cnt - 1'b1));
      S_T_MAP:  ref_rd_addr = map_rdata;
      S_T_REF: begin
        ref_wr_en = ref_rdata != 8'd0;
        ref_wdata = ref_rdata - 8'd1;
      end
      S_SH_CHK: map_rd_addr = MW'(sbase + MW'(i_q));
      S_SH_MAP: ref_rd_addr = map_rdata;
      S_SH_REF: begin
        ref_wr_en = 1'b1;
        ref_wdata = (ref_rdata == 8'hFF) ? 8'hFF : ref_rdata + 8'd1;
        map_wr_en = 1'b1;
      end
      default: ;
    endcase
  end

  pkvba_ref_store #(
    .POOL_BLOCKS(POOL_BLOCKS),
    .BW         (BW)
  ) u_ref (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_addr_i(ref_rd_addr),
    .rd_data_o(ref_rdata),
    .wr_en_i  (ref_wr_en),
    .wr_addr_i(ref_wr_addr),
    .wr_data_i(ref_wdata)
  );

  pkvba_map_ram #(
    .DEPTH(MD),
    .AW   (MW),
    .DW   (BW)
  ) u_map (
    .clk_i    (clk_i),
    .rd_addr_i(map_rd_addr),
    .rd_data_o(map_rdata),
    .wr_en_i  (map_wr_en),
    .wr_addr_i(map_wr_addr),
    .wr_data_i(map_wdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      out_v_q  <= 1'b0;
      sval_q   <= '0;
      used_q   <= '0;
      chk_v_q  <= 1'b0;
      for (int k = 0; k < MAX_REQUESTS; k++) begin
        slen_q[k] <= '0;
        bcnt_q[k] <= '0;
      end
    end else begin
      if (out_v_q && !out_stall_i && !emit_load) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_i;
            state_q <= S_DISP;
          end
        end
        S_DISP: begin
          bv_q   <= 1'b0;
          last_q <= 1'b1;
          i_q    <= '0;
          acc_q  <= '0;
          pres_q <= (req_in && cur_val) ? cur_len : '0;
          case (in_q.op)
            pkvba_pkg::OP_APPEND: begin
              if (!req_in) begin
                st_q    <= pkvba_pkg::ST_ABSENT;
                seqo_q  <= '0;
                state_q <= S_EMIT;
              end else begin
                sval_q[req_idx] <= 1'b1;
                if (in_q.amount == '0) begin
                  st_q    <= pkvba_pkg::ST_ZERO;
                  seqo_q  <= cur_len;
                  state_q <= S_EMIT;
                end else begin
                  st_q    <= pkvba_pkg::ST_OK;
                  rem_q   <= in_q.amount;
                  cur_q   <= dv_q;
                  off_q   <= dv_rem;
                  state_q <= S_A_CHK;
                end
              end
            end
            pkvba_pkg::OP_SHARE: begin
              st_q    <= pkvba_pkg::ST_OK;
              state_q <= S_SH_SRC;
            end
            pkvba_pkg::OP_FREE, pkvba_pkg::OP_TRIM, pkvba_pkg::OP_EVICT,
            pkvba_pkg::OP_QUERY: begin
              if (!(req_in && cur_val)) begin
                st_q    <= pkvba_pkg::ST_ABSENT;
                seqo_q  <= '0;
                state_q <= S_EMIT;
              end else if (in_q.op == pkvba_pkg::OP_QUERY) begin
                st_q    <= pkvba_pkg::ST_OK;
                seqo_q  <= cur_len;
                qn_q    <= (32'(cur_cnt) > pkvba_pkg::QUERY_MAX) ?
                           CW'(pkvba_pkg::QUERY_MAX) : cur_cnt;
                state_q <= (cur_cnt != '0) ? S_Q_RD : S_EMIT;
              end else if (in_q.op != pkvba_pkg::OP_FREE && in_q.amount == '0) begin
                st_q    <= pkvba_pkg::ST_ZERO;
                seqo_q  <= cur_len;
                state_q <= S_EMIT;
              end else begin
                st_q    <= pkvba_pkg::ST_OK;
                state_q <= S_T_CHK;
              end
            end
            default: begin
              st_q    <= pkvba_pkg::ST_OK;
              seqo_q  <= (req_in && cur_val) ? cur_len : '0;
              state_q <= S_EMIT;
            end
          endcase
        end
        S_A_CHK: begin
          seqo_q <= cur_len;
          if (rem_q == '0) begin
            state_q <= S_EMIT;
          end else if (cur_len >= pkvba_pkg::LEN_MAX) begin
            st_q    <= pkvba_pkg::ST_NO_FREE;
            state_q <= S_EMIT;
          end else if (32'(cur_q) >= 32'(cur_cnt)) begin
            if (32'(cur_cnt) >= MAX_BLOCKS_PER_REQ || 32'(used_q) == POOL_BLOCKS) begin
              st_q    <= pkvba_pkg::ST_NO_FREE;
              state_q <= S_EMIT;
            end else begin
              scan_q  <= '0;
              chk_v_q <= 1'b0;
              state_q <= S_A_SCAN;
            end
          end else begin
            state_q <= S_A_MAP;
          end
        end
        S_A_SCAN: begin
          // pipelined scan: read issued for scan_q, data checked for chk_q
          scan_q  <= scan_q + 1'b1;
          chk_q   <= scan_q;
          chk_v_q <= !found;
          if (found) begin
            bcnt_q[req_idx] <= cur_cnt + 1'b1;
            blk_q   <= chk_q;
            used_q  <= used_q + 1'b1;
            state_q <= S_A_ADV;
          end
        end
        S_A_MAP: begin
          blk_q   <= map_rdata;
          state_q <= S_A_ADV;
        end
        S_A_ADV: begin
          slen_q[req_idx] <= cur_len + take;
          rem_q <= rem_q - take;
          bv_q  <= 1'b1;
          if (off_sum == LW'(BLOCK_TOKENS)) begin
            off_q <= '0;
            cur_q <= cur_q + 1'b1;
          end else begin
            off_q <= off_sum;
          end
          state_q <= S_A_CHK;
        end
        S_T_CHK: begin
          if (t_more) begin
            bcnt_q[req_idx] <= cur_cnt - 1'b1;
            i_q     <= i_q + 1'b1;
            acc_q   <= acc_q + ACW'(BLOCK_TOKENS);
            state_q <= S_T_MAP;
          end else begin
            if (in_q.op == pkvba_pkg::OP_FREE) begin
              slen_q[req_idx] <= '0;
              sval_q[req_idx] <= 1'b0;
              seqo_q <= '0;
            end else begin
              slen_q[req_idx] <= trim_len;
              seqo_q <= trim_len;
            end
            state_q <= S_EMIT;
          end
        end
        S_T_MAP: begin
          blk_q   <= map_rdata;
          state_q <= S_T_REF;
        end
        S_T_REF: begin
          if (ref_rdata == 8'd1) used_q <= used_q - 1'b1;
          state_q <= S_T_CHK;
        end
        S_SH_SRC: begin
          if (!req_in || !src_in || !cur_val) begin
            st_q    <= pkvba_pkg::ST_ABSENT;
            seqo_q  <= pres_q;
            state_q <= S_EMIT;
          end else begin
            scnt_q  <= cur_cnt;
            state_q <= S_SH_CHK;
          end
        end
        S_SH_CHK: begin
          if (i_q < scnt_q && 32'(acc_q) < 32'(in_q.amount)) begin
            state_q <= S_SH_MAP;
          end else begin
            bcnt_q[req_idx] <= i_q;
            slen_q[req_idx] <= in_q.amount;
            sval_q[req_idx] <= 1'b1;
            seqo_q  <= in_q.amount;
            state_q <= S_EMIT;
          end
        end
        S_SH_MAP: begin
          blk_q   <= map_rdata;
          state_q <= S_SH_REF;
        end
        S_SH_REF: begin
          if (ref_rdata == 8'd0) used_q <= used_q + 1'b1;
          i_q     <= i_q + 1'b1;
          acc_q   <= acc_q + ACW'(BLOCK_TOKENS);
          state_q <= S_SH_CHK;
        end
        S_Q_RD: state_q <= S_Q_DAT;
        S_Q_DAT: begin
          blk_q   <= map_rdata;
          bv_q    <= 1'b1;
          last_q  <= CW'(i_q + 1'b1) == qn_q;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_load) begin
            out_v_q             <= 1'b1;
            out_q.status        <= st_q;
            out_q.block_index   <= bv_q ? 8'(blk_q) : 8'd0;
            out_q.block_valid   <= bv_q;
            out_q.seq_length    <= seqo_q;
            out_q.blocks_in_use <= 9'(used_q);
            out_q.last          <= last_q;
            if (!last_q) begin
              i_q     <= i_q + 1'b1;
              state_q <= S_Q_RD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= POOL_BLOCKS)
    else $error("used block count above pool size");

  a_scan_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_SCAN && chk_v_q && 32'(chk_q) == POOL_BLOCKS - 1) |-> found)
    else $error("free block scan ran off the end of the pool");

  a_emit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && !bv_q) |-> last_q)
    else $error("non-final beat without a listed block");
`endif

endmodule
